### hw/rtl/vtp_pkg.sv
//------------------------------------------------------------------------------
// vtp_pkg
// Shared constants and types for the vertex transform / projection pipeline.
//------------------------------------------------------------------------------
package vtp_pkg;

	localparam int COORD_BITS_DEF      = 16;
	localparam int COEFF_FRAC_BITS_DEF = 6;
	localparam int COEFF_BITS          = 8;
	localparam int OFFSET_BITS         = 16;
	localparam int CFG_DATA_BITS       = 24;
	localparam int CFG_INDEX_BITS      = 3;
	localparam int RECIP_LOG           = 16;             // numerator 65536
	localparam int QUOT_BITS           = RECIP_LOG + 1;  // quotient 0..65536
	localparam int RECIP_BITS          = QUOT_BITS + 1;  // signed reciprocal
	localparam int PROJ_BASE_SHIFT     = 8;
	localparam int SCREEN_BITS         = 27;
	localparam int VIEWZ_BITS          = 19;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_ROW_X    = 3'd0,
		CFG_ROW_Y    = 3'd1,
		CFG_ROW_Z    = 3'd2,
		CFG_OFFSET_X = 3'd3,
		CFG_OFFSET_Y = 3'd4,
		CFG_OFFSET_Z = 3'd5
	} cfg_idx_t;

	// control that rides along with the divisor
	typedef struct packed {
		logic valid;
		logic neg;   // depth below zero
		logic zero;  // depth exactly zero
	} recip_ctl_t;

endpackage

### hw/rtl/vtp_recip.sv
//------------------------------------------------------------------------------
// vtp_recip
// Pipelined restoring divider: 65536 / d over three stages, sign fix in a fourth.
//------------------------------------------------------------------------------
module vtp_recip #(
	parameter int VW   = 27,
	parameter int SB_W = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv,
	input  vtp_pkg::recip_ctl_t                    ctl,
	input  logic [VW-1:0]                          d_mag,
	input  logic [SB_W-1:0]                        sb_in,
	output logic                                   valid,
	output logic signed [vtp_pkg::RECIP_BITS-1:0]  recip,
	output logic [SB_W-1:0]                        sb_out
);
	import vtp_pkg::*;

	localparam int NST  = 3;
	localparam int STEP = (QUOT_BITS + NST - 1) / NST;
	localparam int QI   = $clog2(QUOT_BITS);

	recip_ctl_t             ctl_s [NST];
	logic [VW-1:0]          d_s   [NST];
	logic [VW-1:0]          r_s   [NST];
	logic [QUOT_BITS-1:0]   q_s   [NST];
	logic [SB_W-1:0]        sb_s  [NST];

	genvar k;
	generate
		for (k = 0; k < NST; k++) begin : g_div
			recip_ctl_t           ctl_i;
			logic [VW-1:0]        d_i;
			logic [VW-1:0]        r_i;
			logic [QUOT_BITS-1:0] q_i;
			logic [SB_W-1:0]      sb_i;
			logic [VW-1:0]        r_o;
			logic [QUOT_BITS-1:0] q_o;

			if (k == 0) begin : g_first
				assign ctl_i = ctl;
				assign d_i   = d_mag;
				assign r_i   = '0;
				assign q_i   = '0;
				assign sb_i  = sb_in;
			end else begin : g_next
				assign ctl_i = ctl_s[k-1];
				assign d_i   = d_s[k-1];
				assign r_i   = r_s[k-1];
				assign q_i   = q_s[k-1];
				assign sb_i  = sb_s[k-1];
			end

			always_comb begin
				logic [VW:0] rs;
				logic [VW:0] r;
				int          bi;
				r   = {1'b0, r_i};
				q_o = q_i;
				for (int j = 0; j < STEP; j++) begin
					bi = QUOT_BITS - 1 - k * STEP - j;
					if (bi >= 0) begin
						rs = {r[VW-1:0], (bi == QUOT_BITS - 1)};
						if (rs >= {1'b0, d_i}) begin
							r = rs - {1'b0, d_i};
							q_o[bi[QI-1:0]] = 1'b1;
						end else begin
							r = rs;
						end
					end
				end
				r_o = r[VW-1:0];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					ctl_s[k] <= '0;
				end else if (adv) begin
					ctl_s[k] <= ctl_i;
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					d_s[k]        <= d_i;
					r_s[k]        <= r_o;
					q_s[k]        <= q_o;
					sb_s[k]       <= sb_i;
				end
			end
		end
	endgenerate

	// sign fix and zero-depth override
	logic signed [RECIP_BITS-1:0] qx;
	logic signed [RECIP_BITS-1:0] rc;
	assign qx = $signed({1'b0, q_s[NST-1]});
	always_comb begin
		priority if (ctl_s[NST-1].zero) rc = RECIP_BITS'(1 << RECIP_LOG);
		else if (ctl_s[NST-1].neg)      rc = -qx;
		else                            rc = qx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (adv) begin
			valid <= ctl_s[NST-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			recip  <= rc;
			sb_out <= sb_s[NST-1];
		end
	end

endmodule

### hw/rtl/vertex_transform_project_top.sv
//------------------------------------------------------------------------------
// vertex_transform_project_top
// Rotates, translates and perspective-projects one vertex per cycle unless stalled.
//------------------------------------------------------------------------------
// Usage:
//  - Input request: model_x/y/z with in_valid; taken when in_valid && !in_stall.
//  - Output request: screen_x/y, view_z with out_valid; taken when !out_stall.
//  - Config: cfg_write with cfg_index / cfg_data writes one register per edge
//    (rows 0..2, offsets 3..5, other indexes ignored). Write only when idle.
//  - Pipeline: registered stages from acceptance to out_valid:
//    s1 products, s2 row sums, s3 scale+offset, s4 depth normalize,
//    s5..s7 restoring divider for 65536/depth, s8 sign fix,
//    s9 coordinate * reciprocal, s10 truncating shift into the output register.
//  - Throughput: one vertex per cycle while no result is held under out_stall;
//    the divider is fully pipelined, six quotient bits per stage (five in s7).
//  - Stall: the whole pipeline freezes while a result waits under out_stall;
//    in_stall is raised for exactly those cycles. Nothing is lost or repeated.
//  - Reset: arst_n clears valid bits and loads identity rows, zero offsets.
//------------------------------------------------------------------------------
module vertex_transform_project_top #(
	parameter int COORD_BITS      = vtp_pkg::COORD_BITS_DEF,
	parameter int COEFF_FRAC_BITS = vtp_pkg::COEFF_FRAC_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_write,
	input  logic [vtp_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
	input  logic [vtp_pkg::CFG_DATA_BITS-1:0]         cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic signed [COORD_BITS-1:0]              model_x,
	input  logic signed [COORD_BITS-1:0]              model_y,
	input  logic signed [COORD_BITS-1:0]              model_z,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [vtp_pkg::SCREEN_BITS-1:0]    screen_x,
	output logic signed [vtp_pkg::SCREEN_BITS-1:0]    screen_y,
	output logic signed [vtp_pkg::VIEWZ_BITS-1:0]     view_z
);
	import vtp_pkg::*;

	localparam int PW    = COORD_BITS + COEFF_BITS;      // one product
	localparam int SUMW  = PW + 2;                       // sum of three
	localparam int VW    = PW + 3;                       // view coordinate
	localparam int LZ_W  = $clog2(VW);
	localparam int SH_W  = $clog2(VW + PROJ_BASE_SHIFT);
	localparam int PPW   = VW + RECIP_BITS;              // projected product
	localparam int SB_W  = 3 * VW + LZ_W;
	localparam logic [SUMW-1:0] FRAC_MASK = SUMW'((1 << COEFF_FRAC_BITS) - 1);

	// configuration
	logic [CFG_DATA_BITS-1:0] row_q [3];
	logic [OFFSET_BITS-1:0]   off_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= CFG_DATA_BITS'(24'h000040);
			row_q[1] <= CFG_DATA_BITS'(24'h004000);
			row_q[2] <= CFG_DATA_BITS'(24'h400000);
			off_q[0] <= '0;
			off_q[1] <= '0;
			off_q[2] <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_ROW_X:    row_q[0] <= cfg_data;
				CFG_ROW_Y:    row_q[1] <= cfg_data;
				CFG_ROW_Z:    row_q[2] <= cfg_data;
				CFG_OFFSET_X: off_q[0] <= cfg_data[OFFSET_BITS-1:0];
				CFG_OFFSET_Y: off_q[1] <= cfg_data[OFFSET_BITS-1:0];
				CFG_OFFSET_Z: off_q[2] <= cfg_data[OFFSET_BITS-1:0];
				default: ;
			endcase
		end
	end

	// global advance: freeze everything while a result is held
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	logic signed [COORD_BITS-1:0] mdl [3];
	assign mdl[0] = model_x;
	assign mdl[1] = model_y;
	assign mdl[2] = model_z;

	logic v_s1, v_s2, v_s3, v_s4, v_s9;
	logic signed [PW-1:0]   prod_s1 [3][3];
	logic signed [SUMW-1:0] sum_s2  [3];
	logic signed [VW-1:0]   view_s3 [3];

	// s1: nine products
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= PW'(mdl[c]) *
						PW'($signed(row_q[r][c*COEFF_BITS +: COEFF_BITS]));
				end
			end
		end
	end

	// s2: row sums
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				sum_s2[r] <= SUMW'(prod_s1[r][0]) + SUMW'(prod_s1[r][1]) +
					SUMW'(prod_s1[r][2]);
			end
		end
	end

	// s3: divide by 2^frac toward zero, add offset
	logic signed [SUMW-1:0] scaled [3];
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			scaled[r] = (sum_s2[r] + (sum_s2[r][SUMW-1] ? $signed(FRAC_MASK) :
				$signed(SUMW'(0)))) >>> COEFF_FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				view_s3[r] <= VW'(scaled[r]) + VW'($signed(off_q[r]));
			end
		end
	end

	// s4: depth normalize -> divisor magnitude and shift
	logic [LZ_W-1:0]     lg;
	logic [LZ_W-1:0]     logz;
	logic signed [VW-1:0] msb;
	logic                pos_z;
	always_comb begin
		lg    = '0;
		pos_z = !view_s3[2][VW-1] && (view_s3[2] != '0);
		for (int i = 0; i < VW - 1; i++) begin
			if (view_s3[2][i]) lg = LZ_W'(i);
		end
		if (pos_z && lg > LZ_W'(PROJ_BASE_SHIFT)) logz = lg - LZ_W'(PROJ_BASE_SHIFT);
		else                                       logz = '0;
		msb = view_s3[2] >>> logz;
	end

	recip_ctl_t          ctl_s4;
	logic                neg_s4;
	logic                zero_s4;
	logic [VW-1:0]       dmag_s4;
	logic [SB_W-1:0]     sb_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s4      <= msb[VW-1];
			zero_s4     <= (view_s3[2] == '0);
			dmag_s4     <= msb[VW-1] ? VW'(-msb) : VW'(msb);
			sb_s4       <= {view_s3[0], view_s3[1], view_s3[2], logz};
		end
	end
	assign ctl_s4 = {v_s4, neg_s4, zero_s4};

	// s5..s8: reciprocal
	logic                         v_s8;
	logic signed [RECIP_BITS-1:0] recip_s8;
	logic [SB_W-1:0]              sb_s8;

	vtp_recip #(
		.VW   (VW),
		.SB_W (SB_W)
	) u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ctl    (ctl_s4),
		.d_mag  (dmag_s4),
		.sb_in  (sb_s4),
		.valid  (v_s8),
		.recip  (recip_s8),
		.sb_out (sb_s8)
	);

	// s9: coordinate * reciprocal
	logic signed [VW-1:0]  vx8, vy8, vz8;
	logic [LZ_W-1:0]       lz8;
	assign {vx8, vy8, vz8, lz8} = sb_s8;

	logic signed [PPW-1:0] px_s9, py_s9;
	logic signed [VW-1:0]  vz_s9;
	logic [LZ_W-1:0]       lz_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s9 <= PPW'(vx8) * PPW'(recip_s8);
			py_s9 <= PPW'(vy8) * PPW'(recip_s8);
			vz_s9 <= vz8;
			lz_s9 <= lz8;
		end
	end

	// s10: divide by 2^(8+logZ) toward zero
	logic [SH_W-1:0]       sh;
	logic signed [PPW-1:0] rmask;
	logic signed [PPW-1:0] sx, sy;
	always_comb begin
		sh    = SH_W'(PROJ_BASE_SHIFT) + SH_W'(lz_s9);
		rmask = $signed((PPW'(1) << sh) - PPW'(1));
		sx    = (px_s9 + (px_s9[PPW-1] ? rmask : $signed(PPW'(0)))) >>> sh;
		sy    = (py_s9 + (py_s9[PPW-1] ? rmask : $signed(PPW'(0)))) >>> sh;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			screen_x <= sx[SCREEN_BITS-1:0];
			screen_y <= sy[SCREEN_BITS-1:0];
			view_z   <= vz_s9[VIEWZ_BITS-1:0];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s9      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s9      <= v_s8;
			out_valid <= v_s9;
		end
	end

endmodule

### hw/rtl/vtp_checker.sv
//------------------------------------------------------------------------------
// vtp_checker
// Port-level checks for the vertex transform pipeline, bound to the top level.
//------------------------------------------------------------------------------
module vtp_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_stall,
	input logic                                   out_valid,
	input logic                                   out_stall,
	input logic signed [vtp_pkg::SCREEN_BITS-1:0] screen_x,
	input logic signed [vtp_pkg::VIEWZ_BITS-1:0]  view_z
);
	import vtp_pkg::*;

	// input backpressure only from a held result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without held result");

	// a free output never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input blocked with free output");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(screen_x) && $stable(view_z)))
		else $error("result changed under stall");

endmodule

bind vertex_transform_project_top vtp_checker u_vtp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.screen_x  (screen_x),
	.view_z    (view_z)
);
